### design/ett_pkg.sv
// Shared types and constants of the tween table.
package ett_pkg;

  localparam logic [1:0] KIND_CREATE = 2'd0;
  localparam logic [1:0] KIND_TICK   = 2'd1;
  localparam logic [1:0] KIND_EVAL   = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [1:0] RSP_CREATED   = 2'd0;
  localparam logic [1:0] RSP_FULL      = 2'd1;
  localparam logic [1:0] RSP_FINISHED  = 2'd2;
  localparam logic [1:0] RSP_EVALUATED = 2'd3;

  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_IN     = 2'd1;
  localparam logic [1:0] MODE_OUT    = 2'd2;
  localparam logic [1:0] MODE_INOUT  = 2'd3;

  localparam logic [16:0] ONE_Q16      = 17'h10000;
  localparam logic [17:0] TWO_Q16      = 18'h20000;
  localparam logic [16:0] HALF_Q16     = 17'h08000;
  localparam logic signed [15:0] VALUE_ONE = 16'sd256;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         mode;
    logic signed [15:0] start_value;
    logic signed [15:0] final_value;
    logic [15:0]        duration;
    logic [15:0]        delta;
    logic [15:0]        handle;
  } item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CREATE,
    S_TICK_UPD,
    S_TICK_EMIT,
    S_REMOVE,
    S_EVAL_SCAN,
    S_DIV,
    S_MUL,
    S_FRAC,
    S_SCALE,
    S_EVAL_OUT,
    S_MISS
  } state_t;

endpackage

### design/ett_req_if.sv
// Request channel of the tween table.
interface ett_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [1:0]         mode;
  logic signed [15:0] start_value;
  logic signed [15:0] final_value;
  logic [15:0]        duration;
  logic [15:0]        delta;
  logic [15:0]        handle;

  modport source(output valid, kind, mode, start_value, final_value, duration, delta, handle,
                 input ready);
  modport sink(input valid, kind, mode, start_value, final_value, duration, delta, handle,
               output ready);
endinterface

### design/ett_rsp_if.sv
// Result channel of the tween table.
interface ett_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind_out;
  logic [15:0]        handle_out;
  logic signed [15:0] value;
  logic               found;
  logic               last;

  modport source(output valid, kind_out, handle_out, value, found, last, input ready);
  modport sink(input valid, kind_out, handle_out, value, found, last, output ready);
endinterface

### design/easing_tween_table.sv
// The back end serves one request at a time; eval uses a 32-step divider.
// Tick walks every slot to update it; if any finished, it walks them all again to report,
// then once more top-down for removal; else it goes straight back to idle.
// Requests queue two deep ahead of the back end; results leave through a register.
// Synchronous reset empties the table and sets the handle counter to one.
module easing_tween_table #(
  parameter int ENTRIES = 16
) (
  input  logic  clk,
  input  logic  rst,
  ett_req_if.sink   req,
  ett_rsp_if.source rsp
);

  logic           q_valid;
  logic           q_pop;
  ett_pkg::item_t q_item;

  ett_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  ett_back #(.ENTRIES(ENTRIES)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .rsp     (rsp)
  );

endmodule

### design/ett_front.sv
// Front end: takes requests, drops unused kinds, queues the rest.
module ett_front (
  input  logic             clk,
  input  logic             rst,
  ett_req_if.sink          req,
  output logic             q_valid,
  output ett_pkg::item_t   q_item,
  input  logic             q_pop
);

  ett_pkg::item_t    fifo [ett_pkg::QUEUE_DEPTH];
  logic [0:0]        wptr;
  logic [0:0]        rptr;
  logic [1:0]        fill;
  logic              push;
  ett_pkg::item_t    in_item;

  assign req.ready = (fill != 2'(ett_pkg::QUEUE_DEPTH));
  assign push      = req.valid && req.ready && (req.kind != ett_pkg::KIND_UNUSED);
  assign q_valid   = (fill != 2'd0);
  assign q_item    = fifo[rptr];

  always_comb begin
    in_item.kind        = req.kind;
    in_item.mode        = req.mode;
    in_item.start_value = req.start_value;
    in_item.final_value = req.final_value;
    in_item.duration    = req.duration;
    in_item.delta       = req.delta;
    in_item.handle      = req.handle;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wptr] <= in_item;
    end
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (q_pop) begin
        rptr <= rptr + 1'b1;
      end
      fill <= fill + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

### design/ett_back.sv
// Back end: tween table, tick walk, removal and eased evaluation.
module ett_back #(
  parameter int ENTRIES = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  ett_pkg::item_t   q_item,
  output logic             q_pop,
  ett_rsp_if.source        rsp
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  ett_pkg::state_t state, state_next;
  ett_pkg::item_t  cmd;

  logic [15:0]        e_handle   [ENTRIES];
  logic [1:0]         e_mode     [ENTRIES];
  logic signed [15:0] e_start    [ENTRIES];
  logic signed [15:0] e_final    [ENTRIES];
  logic [15:0]        e_duration [ENTRIES];
  logic [15:0]        e_elapsed  [ENTRIES];
  logic [ENTRIES-1:0] done;

  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] kcnt;
  logic [CW-1:0] top;
  logic [CW-1:0] jdx;
  logic [15:0]   next_handle;

  logic [IW-1:0] rd_addr;
  logic [15:0]   r_handle;
  logic [15:0]   r_elapsed;
  logic [15:0]   r_duration;
  logic [16:0]   sum;
  logic          fin;

  logic [1:0]         ev_mode;
  logic signed [15:0] ev_start;
  logic signed [15:0] ev_final;
  logic [15:0]        ev_duration;
  logic [31:0]        dq;
  logic [16:0]        drem;
  logic [4:0]         dcnt;
  logic [17:0]        dtry;
  logic               dge;
  logic [16:0]        t;
  logic [16:0]        s;
  logic [16:0]        mul_a;
  logic [17:0]        mul_b;
  logic [5:0]         mul_sh;
  logic               mul_add;
  logic [34:0]        prod;
  logic [5:0]         sh;
  logic               addhi;
  logic [34:0]        prod_adj;
  logic [16:0]        frac;
  logic signed [16:0] diff;
  logic signed [34:0] scaled;

  logic        ofree;
  logic        emit;
  logic [1:0]  o_kind;
  logic [15:0] o_handle;
  logic signed [15:0] o_value;
  logic        o_found;
  logic        o_last;
  logic        is_full;

  logic        ovalid;
  logic [1:0]  rkind;
  logic [15:0] rhandle;
  logic signed [15:0] rvalue;
  logic        rfound;
  logic        rlast;

  assign top     = count - 1'b1;
  assign jdx     = idx - 1'b1;
  assign rd_addr = (state == ett_pkg::S_REMOVE) ? top[IW-1:0] : idx[IW-1:0];
  assign r_handle   = e_handle[rd_addr];
  assign r_elapsed  = e_elapsed[rd_addr];
  assign r_duration = e_duration[rd_addr];
  assign sum = {1'b0, r_elapsed} + {1'b0, cmd.delta};
  assign fin = (sum >= {1'b0, r_duration});
  assign is_full = (count == CW'(ENTRIES));
  assign ofree = !ovalid || rsp.ready;

  // restoring divider step
  assign dtry = {drem, dq[31]} ;
  assign dge  = ({1'b0, dtry} >= {3'b000, ev_duration});

  always_comb begin
    if (ev_duration == 16'd0 || dq > {15'd0, ett_pkg::ONE_Q16}) begin
      t = ett_pkg::ONE_Q16;
    end else begin
      t = dq[16:0];
    end
  end

  assign s = {t[15:0], 1'b0} - ett_pkg::ONE_Q16;

  always_comb begin
    mul_a   = t;
    mul_b   = 18'd1;
    mul_sh  = 6'd0;
    mul_add = 1'b0;
    unique case (ev_mode)
      ett_pkg::MODE_LINEAR: begin
        mul_b = 18'd1;
      end
      ett_pkg::MODE_IN: begin
        mul_b  = {1'b0, t};
        mul_sh = 6'd16;
      end
      ett_pkg::MODE_OUT: begin
        mul_b  = ett_pkg::TWO_Q16 - {1'b0, t};
        mul_sh = 6'd16;
      end
      ett_pkg::MODE_INOUT: begin
        if (t < ett_pkg::HALF_Q16) begin
          mul_b  = {1'b0, t};
          mul_sh = 6'd15;
        end else begin
          mul_a   = s;
          mul_b   = ett_pkg::TWO_Q16 - {1'b0, s};
          mul_sh  = 6'd17;
          mul_add = 1'b1;
        end
      end
      default: begin
        mul_b = 18'd1;
      end
    endcase
  end

  assign prod_adj = addhi ? (prod + 35'h100000000) : prod;
  assign diff     = 17'(ev_final) - 17'(ev_start);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ett_pkg::S_IDLE: begin
        if (q_valid) begin
          priority case (q_item.kind)
            ett_pkg::KIND_CREATE: state_next = ett_pkg::S_CREATE;
            ett_pkg::KIND_TICK:   state_next = ett_pkg::S_TICK_UPD;
            ett_pkg::KIND_EVAL:   state_next = (q_item.handle == 16'd0) ?
                                               ett_pkg::S_MISS : ett_pkg::S_EVAL_SCAN;
            default:              state_next = ett_pkg::S_IDLE;
          endcase
        end
      end
      ett_pkg::S_CREATE:
        if (ofree) state_next = ett_pkg::S_IDLE;
      ett_pkg::S_TICK_UPD:
        if (idx == count) begin
          state_next = (kcnt == '0) ? ett_pkg::S_IDLE : ett_pkg::S_TICK_EMIT;
        end
      ett_pkg::S_TICK_EMIT:
        if (idx == count) state_next = ett_pkg::S_REMOVE;
      ett_pkg::S_REMOVE:
        if (idx == '0) state_next = ett_pkg::S_IDLE;
      ett_pkg::S_EVAL_SCAN: begin
        if (idx == count) begin
          state_next = ett_pkg::S_MISS;
        end else if (r_handle == cmd.handle) begin
          state_next = ett_pkg::S_DIV;
        end
      end
      ett_pkg::S_DIV:
        if (dcnt == 5'd31) state_next = ett_pkg::S_MUL;
      ett_pkg::S_MUL:   state_next = ett_pkg::S_FRAC;
      ett_pkg::S_FRAC:  state_next = ett_pkg::S_SCALE;
      ett_pkg::S_SCALE: state_next = ett_pkg::S_EVAL_OUT;
      ett_pkg::S_EVAL_OUT, ett_pkg::S_MISS:
        if (ofree) state_next = ett_pkg::S_IDLE;
      default: state_next = ett_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop    = 1'b0;
    emit     = 1'b0;
    o_kind   = ett_pkg::RSP_CREATED;
    o_handle = 16'd0;
    o_value  = 16'sd0;
    o_found  = 1'b0;
    o_last   = 1'b1;
    unique case (state)
      ett_pkg::S_IDLE: q_pop = q_valid;
      ett_pkg::S_CREATE: begin
        emit     = ofree;
        o_kind   = is_full ? ett_pkg::RSP_FULL : ett_pkg::RSP_CREATED;
        o_handle = is_full ? 16'd0 : next_handle;
      end
      ett_pkg::S_TICK_EMIT: begin
        emit     = ofree && (idx != count) && done[idx[IW-1:0]];
        o_kind   = ett_pkg::RSP_FINISHED;
        o_handle = r_handle;
        o_last   = (kcnt == CW'(1));
      end
      ett_pkg::S_EVAL_OUT: begin
        emit     = ofree;
        o_kind   = ett_pkg::RSP_EVALUATED;
        o_handle = cmd.handle;
        o_value  = ev_start + scaled[31:16];
        o_found  = 1'b1;
      end
      ett_pkg::S_MISS: begin
        emit     = ofree;
        o_kind   = ett_pkg::RSP_EVALUATED;
        o_handle = cmd.handle;
        o_value  = ett_pkg::VALUE_ONE;
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_item;
    end
    if (state == ett_pkg::S_CREATE && ofree && !is_full) begin
      e_handle[count[IW-1:0]]   <= next_handle;
      e_mode[count[IW-1:0]]     <= cmd.mode;
      e_start[count[IW-1:0]]    <= cmd.start_value;
      e_final[count[IW-1:0]]    <= cmd.final_value;
      e_duration[count[IW-1:0]] <= cmd.duration;
      e_elapsed[count[IW-1:0]]  <= 16'd0;
    end
    if (state == ett_pkg::S_TICK_UPD && idx != count) begin
      e_elapsed[idx[IW-1:0]] <= fin ? r_duration : sum[15:0];
    end
    if (state == ett_pkg::S_REMOVE && idx != '0 && done[jdx[IW-1:0]]) begin
      e_handle[jdx[IW-1:0]]   <= e_handle[rd_addr];
      e_mode[jdx[IW-1:0]]     <= e_mode[rd_addr];
      e_start[jdx[IW-1:0]]    <= e_start[rd_addr];
      e_final[jdx[IW-1:0]]    <= e_final[rd_addr];
      e_duration[jdx[IW-1:0]] <= r_duration;
      e_elapsed[jdx[IW-1:0]]  <= r_elapsed;
    end
    if (state == ett_pkg::S_EVAL_SCAN && idx != count && r_handle == cmd.handle) begin
      ev_mode     <= e_mode[rd_addr];
      ev_start    <= e_start[rd_addr];
      ev_final    <= e_final[rd_addr];
      ev_duration <= r_duration;
      dq          <= {r_elapsed, 16'd0};
      drem        <= 17'd0;
    end
    if (state == ett_pkg::S_DIV) begin
      drem <= dge ? 17'(dtry - {2'b00, ev_duration}) : dtry[16:0];
      dq   <= {dq[30:0], dge};
    end
    if (state == ett_pkg::S_MUL) begin
      prod  <= 35'(mul_a * mul_b);
      sh    <= mul_sh;
      addhi <= mul_add;
    end
    if (state == ett_pkg::S_FRAC) begin
      frac <= 17'(prod_adj >> sh);
    end
    if (state == ett_pkg::S_SCALE) begin
      scaled <= 35'(diff * $signed({1'b0, frac}));
    end
    if (emit) begin
      rkind   <= o_kind;
      rhandle <= o_handle;
      rvalue  <= o_value;
      rfound  <= o_found;
      rlast   <= o_last;
    end

    if (rst) begin
      state       <= ett_pkg::S_IDLE;
      count       <= '0;
      idx         <= '0;
      kcnt        <= '0;
      dcnt        <= '0;
      next_handle <= 16'd1;
      done        <= '0;
      ovalid      <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        ovalid <= 1'b1;
      end else if (rsp.ready) begin
        ovalid <= 1'b0;
      end
      unique case (state)
        ett_pkg::S_IDLE: begin
          idx  <= '0;
          kcnt <= '0;
          dcnt <= '0;
        end
        ett_pkg::S_CREATE: begin
          if (ofree && !is_full) begin
            count       <= count + 1'b1;
            next_handle <= (next_handle == 16'hFFFF) ? 16'd1 : next_handle + 16'd1;
          end
        end
        ett_pkg::S_TICK_UPD: begin
          if (idx == count) begin
            idx <= '0;
          end else begin
            done[idx[IW-1:0]] <= fin;
            kcnt <= kcnt + CW'(fin);
            idx  <= idx + 1'b1;
          end
        end
        ett_pkg::S_TICK_EMIT: begin
          if (idx != count) begin
            if (!done[idx[IW-1:0]]) begin
              idx <= idx + 1'b1;
            end else if (ofree) begin
              idx  <= idx + 1'b1;
              kcnt <= kcnt - 1'b1;
            end
          end
        end
        ett_pkg::S_REMOVE: begin
          if (idx != '0) begin
            idx <= jdx;
            // slots above jdx are already clear, so the moved entry is never finished
            if (done[jdx[IW-1:0]]) begin
              done[jdx[IW-1:0]] <= 1'b0;
              count <= top;
            end
          end
        end
        ett_pkg::S_EVAL_SCAN: begin
          if (idx != count && r_handle != cmd.handle) begin
            idx <= idx + 1'b1;
          end
        end
        ett_pkg::S_DIV: dcnt <= dcnt + 5'd1;
        default: dcnt <= dcnt;
      endcase
    end
  end

  assign rsp.valid      = ovalid;
  assign rsp.kind_out   = rkind;
  assign rsp.handle_out = rhandle;
  assign rsp.value      = rvalue;
  assign rsp.found      = rfound;
  assign rsp.last       = rlast;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ENTRIES)) else $error("entry count above table size");
  a_handle_nonzero: assert property (@(posedge clk) disable iff (rst)
    next_handle != 16'd0) else $error("handle counter reached zero");
  a_full_keeps: assert property (@(posedge clk) disable iff (rst)
    (state == ett_pkg::S_CREATE && is_full) |=> (count == $past(count)))
    else $error("full table changed on create");
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == ett_pkg::S_IDLE) |-> (done == '0))
    else $error("finished flags left after removal");

endmodule
